// ----- hw/rtl/arp_pkg.sv -----
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the arpeggiator engine.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int MAX_NOTES   = 16;
  localparam int NOTE_IDX_W  = $clog2(MAX_NOTES);
  localparam int NOTE_CNT_W  = NOTE_IDX_W + 1;
  localparam int TICK_SHIFT  = 2;

  localparam int DIVIDEND_W  = 32;
  localparam int DIVISOR_W   = 10;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

  localparam logic [19:0] GATE_RECIP  = 20'd671089;
  localparam int          GATE_SHIFT  = 26;
  localparam logic [6:0]  GATE_LEGATO = 7'd100;
  localparam logic [6:0]  PITCH_MAX   = 7'd127;
  localparam logic [6:0]  VEL_ON      = 7'd127;
  localparam logic [6:0]  VEL_OFF     = 7'd0;
  localparam logic signed [4:0] SPAN_FOLD = 5'sd5;
  localparam logic [15:0] LFSR_SEED   = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_SPARE    = 2'd3;

  localparam logic [3:0] MODE_ORDER     = 4'd0;
  localparam logic [3:0] MODE_UP        = 4'd1;
  localparam logic [3:0] MODE_DOWN      = 4'd2;
  localparam logic [3:0] MODE_UPDOWN    = 4'd3;
  localparam logic [3:0] MODE_DOWNUP    = 4'd4;
  localparam logic [3:0] MODE_UPANDDOWN = 4'd5;
  localparam logic [3:0] MODE_DOWNANDUP = 4'd6;
  localparam logic [3:0] MODE_CONVERGE  = 4'd7;
  localparam logic [3:0] MODE_DIVERGE   = 4'd8;
  localparam logic [3:0] MODE_RANDOM    = 4'd9;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SPAN   = 3'd1;
  localparam logic [2:0] REG_HOLD   = 3'd2;
  localparam logic [2:0] REG_DIVSOR = 3'd3;
  localparam logic [2:0] REG_GATE   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON_SCAN,
    S_OFF_SCAN,
    S_TICK_DIV,
    S_WAIT_TICK,
    S_PAT_START,
    S_WAIT_PAT,
    S_RAND_START,
    S_WAIT_RAND,
    S_RANK_LOAD,
    S_RANK_CNT,
    S_UPDATE,
    S_PITCH,
    S_WAIT_LEN,
    S_EMIT_ON,
    S_EMIT_OFF
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ----- hw/rtl/arp_div.sv -----
// ----------------------------------------------------------------------------
// arp_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module arp_div (
  input  logic              clk,
  input  logic              rst,
  input  arp_pkg::div_req_t req,
  output arp_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [arp_pkg::DIV_CNT_W-1:0]   cnt;
  logic [arp_pkg::DIVIDEND_W-1:0]  num;
  logic [arp_pkg::DIVISOR_W-1:0]   rem;
  logic [arp_pkg::DIVISOR_W-1:0]   den;
  logic [arp_pkg::DIVISOR_W:0]     trial;
  logic                            ge;
  logic [arp_pkg::DIVISOR_W-1:0]   rem_next;

  always_comb begin
    trial    = {rem, num[arp_pkg::DIVIDEND_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? arp_pkg::DIVISOR_W'(trial - {1'b0, den})
                  : trial[arp_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == arp_pkg::DIV_CNT_W'(arp_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[arp_pkg::DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- hw/rtl/arpeggiator_engine.sv -----
// ----------------------------------------------------------------------------
// arpeggiator_engine
// Arpeggiator: pitch-sorted held-note set, step pattern and octave walk.
//
// Input channel (s_*): one item per note-on, note-off or clock tick, op in
// s_tuser. Output channel (m_*): a tick on a step boundary yields two items,
// the note-on at the tick and the note-off at the gate end (tlast set).
// Configuration through the APB port, to be written only while the block is
// idle; the user is bound to this, the block does not enforce it. s_tready
// is high only in idle. A note-on or note-off scans the stored notes, one
// stored note compared per cycle. A tick returns to idle when its number is
// not a multiple of four or no note is held, else it runs the step test on
// the shared divider. A tick on a step boundary runs the pattern modulo on
// the same divider unless the pattern needs none, and random mode runs a
// second modulo; play-order mode adds the rank search over the held notes.
// The gate length uses a constant reciprocal multiply.
// Reset: notes cleared, step position -1, LFSR seeded, registers at defaults.
// A stalled receiver holds the block in the emit states; no item is lost.
// ----------------------------------------------------------------------------
module arpeggiator_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pitch_in[6:0], tick_count[38:7], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // event_tick[31:0], pitch_out[38:32], velocity[45:39]
  output logic [0:0]  m_tuser,   // event_kind[0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NI = arp_pkg::NOTE_IDX_W;
  localparam int NC = arp_pkg::NOTE_CNT_W;

  arp_pkg::state_t state, state_next;

  logic [3:0]        mode;
  logic signed [4:0] octave_span;
  logic              hold_enable;
  logic [9:0]        step_divisor;
  logic [6:0]        gate_percent;

  logic [6:0]  held_pitch [arp_pkg::MAX_NOTES];
  logic [15:0] held_age   [arp_pkg::MAX_NOTES];

  logic [NC-1:0]     note_total;
  logic [NC-1:0]     pressed_total;
  logic signed [5:0] step_position;
  logic [NI-1:0]     play_index;
  logic [15:0]       next_age;
  logic signed [4:0] octave_offset;
  logic signed [1:0] octave_dir;
  logic [15:0]       lfsr;

  logic [1:0]  op_r;
  logic [6:0]  pin_r;
  logic [31:0] tick_r;
  logic [31:0] off_tick;
  logic [6:0]  pitch_r;
  logic [18:0] gprod_r;
  logic [NC-1:0] ptr;
  logic [NC-1:0] k_r;
  logic [NC-1:0] cnt_r;
  logic [15:0]   agek;
  logic [5:0]    rank_r;
  logic [5:0]    snew;
  logic [5:0]    idx_r;

  arp_pkg::div_req_t div_req;
  arp_pkg::div_rsp_t div_rsp;

  arp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic          wr_en;
  logic          accept;
  logic          clr_engine;
  logic [NI-1:0] rd_idx;
  logic [6:0]    pitch_rd;
  logic [15:0]   age_rd;
  logic [5:0]    n6;
  logic [5:0]    nm1;
  logic [5:0]    u6;
  logic [5:0]    s2;
  logic [5:0]    half;
  logic [5:0]    fold;
  logic [5:0]    idx_pat;
  logic [9:0]    sd_eff;
  logic [9:0]    pat_mod;
  logic          pat_skip;
  logic          tick_skip;
  logic [NC-1:0] cnt_nx;
  logic [5:0]    pi6;
  logic [5:0]    sel;
  logic signed [9:0] pitch_sum;
  logic [6:0]    pitch_clamp;
  logic [18:0]   gate_prod;
  logic [38:0]   gate_mul;
  logic [12:0]   gate_quot;
  logic [31:0]   len;
  logic          rev;
  logic [15:0]   lfsr_nx;
  logic signed [4:0] oct;
  logic              both;
  logic signed [5:0] osum;
  logic signed [4:0] off_nx;
  logic signed [1:0] dir_nx;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= arp_pkg::MODE_UP;
      octave_span  <= '0;
      hold_enable  <= 1'b0;
      step_divisor <= 10'd12;
      gate_percent <= 7'd50;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        arp_pkg::REG_MODE:   mode         <= pwdata[3:0];
        arp_pkg::REG_SPAN:   octave_span  <= $signed(pwdata[4:0]);
        arp_pkg::REG_HOLD:   hold_enable  <= pwdata[0];
        arp_pkg::REG_DIVSOR: step_divisor <= pwdata[9:0];
        arp_pkg::REG_GATE:   gate_percent <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      arp_pkg::REG_MODE:   prdata = {28'd0, mode};
      arp_pkg::REG_SPAN:   prdata = {27'd0, octave_span};
      arp_pkg::REG_HOLD:   prdata = {31'd0, hold_enable};
      arp_pkg::REG_DIVSOR: prdata = {22'd0, step_divisor};
      arp_pkg::REG_GATE:   prdata = {25'd0, gate_percent};
      default:             prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ datapath
  assign accept = s_tvalid & s_tready;
  assign clr_engine = accept &&
      (((s_tuser == arp_pkg::OP_NOTE_ON) && hold_enable && (pressed_total == '0)) ||
       ((s_tuser == arp_pkg::OP_TICK) && !hold_enable && (pressed_total == '0)));

  assign pitch_rd = held_pitch[rd_idx];
  assign age_rd   = held_age[rd_idx];

  assign n6     = 6'(note_total);
  assign nm1    = n6 - 6'd1;
  assign u6     = 6'(unsigned'(step_position) + 6'd1);
  assign s2     = div_rsp.remainder[5:0];
  assign half   = {1'b0, s2[5:1]};
  assign sd_eff = (step_divisor == '0) ? 10'd1 : step_divisor;
  assign gate_prod = 19'({sd_eff, {arp_pkg::TICK_SHIFT{1'b0}}} * gate_percent);
  assign tick_skip = (tick_r[arp_pkg::TICK_SHIFT-1:0] != '0) || (note_total == '0);
  assign pat_skip  = (mode > arp_pkg::MODE_RANDOM) ||
      (((mode == arp_pkg::MODE_UPDOWN) || (mode == arp_pkg::MODE_DOWNUP)) && (n6 < 6'd2));
  assign cnt_nx = cnt_r + NC'(age_rd < agek);
  assign rev = (mode == arp_pkg::MODE_DOWN) || (mode == arp_pkg::MODE_DOWNUP) ||
               (mode == arp_pkg::MODE_DOWNANDUP);
  assign lfsr_nx = lfsr[0] ? ((lfsr >> 1) ^ arp_pkg::LFSR_TAPS) : (lfsr >> 1);

  always_comb begin
    if ((mode == arp_pkg::MODE_UPDOWN) || (mode == arp_pkg::MODE_DOWNUP))
      pat_mod = 10'({nm1, 1'b0});
    else if ((mode == arp_pkg::MODE_UPANDDOWN) || (mode == arp_pkg::MODE_DOWNANDUP))
      pat_mod = 10'({n6, 1'b0});
    else
      pat_mod = 10'(n6);
  end

  always_comb begin
    fold    = '0;
    idx_pat = '0;
    unique case (mode)
      arp_pkg::MODE_UP, arp_pkg::MODE_DOWN: idx_pat = s2;
      arp_pkg::MODE_UPDOWN, arp_pkg::MODE_DOWNUP: begin
        fold    = (s2 < nm1) ? s2 : s2 - nm1;
        idx_pat = (s2 >= nm1) ? n6 - fold - 6'd1 : fold;
      end
      arp_pkg::MODE_UPANDDOWN, arp_pkg::MODE_DOWNANDUP: begin
        fold    = (s2 < n6) ? s2 : s2 - n6;
        idx_pat = (s2 >= n6) ? n6 - fold - 6'd1 : fold;
      end
      arp_pkg::MODE_CONVERGE: idx_pat = s2[0] ? n6 - half - 6'd1 : half;
      arp_pkg::MODE_DIVERGE:
        idx_pat = s2[0] ? (n6 >> 1) - half - 6'd1 : (n6 >> 1) + half;
      default: idx_pat = '0;
    endcase
  end

  always_comb begin
    both = (octave_span > arp_pkg::SPAN_FOLD) || (octave_span < -arp_pkg::SPAN_FOLD);
    if (octave_span > arp_pkg::SPAN_FOLD)       oct = octave_span - arp_pkg::SPAN_FOLD;
    else if (octave_span < -arp_pkg::SPAN_FOLD) oct = octave_span + arp_pkg::SPAN_FOLD;
    else                                        oct = octave_span;
    osum   = 6'(octave_offset) + 6'(octave_dir);
    off_nx = octave_offset;
    dir_nx = octave_dir;
    if (oct == 5'sd0) begin
      off_nx = '0;
      dir_nx = '0;
    end else if (oct > 5'sd0) begin
      if (octave_dir == 2'sd0) begin
        dir_nx = 2'sd1;
      end else if (osum > 6'(oct)) begin
        off_nx = both ? oct : 5'sd0;
        dir_nx = both ? -2'sd1 : 2'sd1;
      end else if (osum < 6'sd0) begin
        off_nx = '0;
        dir_nx = 2'sd1;
      end else begin
        off_nx = 5'(osum);
      end
    end else begin
      if (octave_dir == 2'sd0) begin
        dir_nx = -2'sd1;
      end else if (osum < 6'(oct)) begin
        off_nx = both ? oct : 5'sd0;
        dir_nx = both ? 2'sd1 : -2'sd1;
      end else if (osum > 6'sd0) begin
        off_nx = '0;
        dir_nx = -2'sd1;
      end else begin
        off_nx = 5'(osum);
      end
    end
  end

  always_comb begin
    pi6 = 6'(play_index);
    sel = (octave_dir == -2'sd1) ? n6 - pi6 - 6'd1 : pi6;
    if (sel >= n6) sel = '0;
    pitch_sum = $signed(10'(pitch_rd)) + (10'(octave_offset) <<< 3)
              + (10'(octave_offset) <<< 2);
    if (pitch_sum < 10'sd0)                     pitch_clamp = '0;
    else if (pitch_sum > 10'(arp_pkg::PITCH_MAX)) pitch_clamp = arp_pkg::PITCH_MAX;
    else                                        pitch_clamp = pitch_sum[6:0];
    gate_mul  = 39'(gprod_r) * 39'(arp_pkg::GATE_RECIP);
    gate_quot = gate_mul[arp_pkg::GATE_SHIFT +: 13];
    len = (gate_quot == '0) ? 32'd1 : 32'(gate_quot);
    if (gate_percent == arp_pkg::GATE_LEGATO) len = len + 32'd1;
  end

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= arp_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      arp_pkg::S_IDLE:
        if (s_tvalid) begin
          priority case (s_tuser)
            arp_pkg::OP_NOTE_ON:  state_next = arp_pkg::S_ON_SCAN;
            arp_pkg::OP_NOTE_OFF: state_next = arp_pkg::S_OFF_SCAN;
            arp_pkg::OP_TICK:     state_next = arp_pkg::S_TICK_DIV;
            default:              state_next = arp_pkg::S_IDLE;
          endcase
        end
      arp_pkg::S_ON_SCAN:
        if (note_total >= NC'(arp_pkg::MAX_NOTES)) state_next = arp_pkg::S_IDLE;
        else if ((ptr < note_total) && (pin_r > pitch_rd)) state_next = arp_pkg::S_ON_SCAN;
        else state_next = arp_pkg::S_IDLE;
      arp_pkg::S_OFF_SCAN:
        if ((ptr >= note_total) || (pitch_rd == pin_r)) state_next = arp_pkg::S_IDLE;
      arp_pkg::S_TICK_DIV:
        state_next = tick_skip ? arp_pkg::S_IDLE : arp_pkg::S_WAIT_TICK;
      arp_pkg::S_WAIT_TICK:
        if (div_rsp.done)
          state_next = (div_rsp.remainder == '0) ? arp_pkg::S_PAT_START : arp_pkg::S_IDLE;
      arp_pkg::S_PAT_START:
        state_next = pat_skip ? arp_pkg::S_UPDATE : arp_pkg::S_WAIT_PAT;
      arp_pkg::S_WAIT_PAT:
        if (div_rsp.done) begin
          if (mode == arp_pkg::MODE_RANDOM)     state_next = arp_pkg::S_RAND_START;
          else if (mode == arp_pkg::MODE_ORDER) state_next = arp_pkg::S_RANK_LOAD;
          else                                  state_next = arp_pkg::S_UPDATE;
        end
      arp_pkg::S_RAND_START: state_next = arp_pkg::S_WAIT_RAND;
      arp_pkg::S_WAIT_RAND:  if (div_rsp.done) state_next = arp_pkg::S_UPDATE;
      arp_pkg::S_RANK_LOAD:  state_next = arp_pkg::S_RANK_CNT;
      arp_pkg::S_RANK_CNT:
        if (ptr == note_total - 1'b1) begin
          if ((6'(cnt_nx) == rank_r) || (k_r == note_total - 1'b1))
            state_next = arp_pkg::S_UPDATE;
          else
            state_next = arp_pkg::S_RANK_LOAD;
        end
      arp_pkg::S_UPDATE:   state_next = arp_pkg::S_PITCH;
      arp_pkg::S_PITCH:    state_next = arp_pkg::S_WAIT_LEN;
      arp_pkg::S_WAIT_LEN: state_next = arp_pkg::S_EMIT_ON;
      arp_pkg::S_EMIT_ON:  if (m_tready) state_next = arp_pkg::S_EMIT_OFF;
      arp_pkg::S_EMIT_OFF: if (m_tready) state_next = arp_pkg::S_IDLE;
      default:             state_next = arp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == arp_pkg::S_IDLE);
    m_tvalid = (state == arp_pkg::S_EMIT_ON) || (state == arp_pkg::S_EMIT_OFF);
    div_req  = '0;
    rd_idx   = ptr[NI-1:0];
    unique case (state)
      arp_pkg::S_TICK_DIV: begin
        div_req.start    = !tick_skip;
        div_req.dividend = 32'(tick_r >> arp_pkg::TICK_SHIFT);
        div_req.divisor  = sd_eff;
      end
      arp_pkg::S_PAT_START: begin
        div_req.start    = !pat_skip;
        div_req.dividend = 32'(u6);
        div_req.divisor  = pat_mod;
      end
      arp_pkg::S_RAND_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'(lfsr);
        div_req.divisor  = 10'(n6);
      end
      arp_pkg::S_RANK_LOAD: rd_idx = k_r[NI-1:0];
      arp_pkg::S_PITCH:     rd_idx = sel[NI-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_total    <= '0;
      pressed_total <= '0;
      step_position <= -6'sd1;
      play_index    <= '0;
      next_age      <= '0;
      octave_offset <= '0;
      octave_dir    <= '0;
      lfsr          <= arp_pkg::LFSR_SEED;
    end else begin
      if (clr_engine) begin
        note_total    <= '0;
        pressed_total <= '0;
        step_position <= -6'sd1;
        play_index    <= '0;
        next_age      <= '0;
        octave_offset <= '0;
        octave_dir    <= '0;
      end
      unique case (state)
        arp_pkg::S_ON_SCAN:
          if ((note_total < NC'(arp_pkg::MAX_NOTES)) &&
              !((ptr < note_total) && (pin_r > pitch_rd)) &&
              !((ptr < note_total) && (pin_r == pitch_rd))) begin
            note_total    <= note_total + 1'b1;
            pressed_total <= pressed_total + 1'b1;
            next_age      <= next_age + 16'd1;
          end
        arp_pkg::S_OFF_SCAN:
          if ((ptr < note_total) && (pitch_rd == pin_r)) begin
            if (pressed_total != '0) pressed_total <= pressed_total - 1'b1;
            if (!hold_enable) note_total <= note_total - 1'b1;
          end
        arp_pkg::S_WAIT_PAT:
          if (div_rsp.done && (mode == arp_pkg::MODE_RANDOM)) lfsr <= lfsr_nx;
        arp_pkg::S_UPDATE: begin
          step_position <= $signed(snew);
          play_index    <= rev ? NI'(n6 - idx_r - 6'd1) : idx_r[NI-1:0];
          if (snew == '0) begin
            octave_offset <= off_nx;
            octave_dir    <= dir_nx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= s_tuser;
      pin_r  <= s_tdata[6:0];
      tick_r <= s_tdata[38:7];
      ptr    <= '0;
    end
    unique case (state)
      arp_pkg::S_ON_SCAN:
        if ((ptr < note_total) && (pin_r > pitch_rd)) begin
          ptr <= ptr + 1'b1;
        end else if ((note_total < NC'(arp_pkg::MAX_NOTES)) &&
                     !((ptr < note_total) && (pin_r == pitch_rd))) begin
          for (int i = 0; i < arp_pkg::MAX_NOTES; i++) begin
            if (NC'(i) == ptr) begin
              held_pitch[i] <= pin_r;
              held_age[i]   <= next_age;
            end else if ((NC'(i) > ptr) && (NC'(i) <= note_total) && (i > 0)) begin
              held_pitch[i] <= held_pitch[i-1];
              held_age[i]   <= held_age[i-1];
            end
          end
        end
      arp_pkg::S_OFF_SCAN:
        if ((ptr < note_total) && (pitch_rd == pin_r)) begin
          if (!hold_enable) begin
            for (int j = 0; j < arp_pkg::MAX_NOTES - 1; j++) begin
              if ((NC'(j) >= ptr) && (NC'(j) < note_total - 1'b1)) begin
                held_pitch[j] <= held_pitch[j+1];
                held_age[j]   <= held_age[j+1];
              end
            end
          end
        end else begin
          ptr <= ptr + 1'b1;
        end
      arp_pkg::S_PAT_START:
        if (pat_skip) begin
          snew  <= (mode > arp_pkg::MODE_RANDOM) ? unsigned'(step_position) : 6'd0;
          idx_r <= '0;
        end
      arp_pkg::S_WAIT_PAT:
        if (div_rsp.done) begin
          snew   <= s2;
          idx_r  <= idx_pat;
          rank_r <= s2;
          k_r    <= '0;
        end
      arp_pkg::S_WAIT_RAND:
        if (div_rsp.done) idx_r <= s2;
      arp_pkg::S_RANK_LOAD: begin
        agek  <= age_rd;
        ptr   <= '0;
        cnt_r <= '0;
      end
      arp_pkg::S_RANK_CNT:
        if (ptr == note_total - 1'b1) begin
          if (6'(cnt_nx) == rank_r) idx_r <= 6'(k_r);
          else if (k_r == note_total - 1'b1) idx_r <= '0;
          else k_r <= k_r + 1'b1;
        end else begin
          ptr   <= ptr + 1'b1;
          cnt_r <= cnt_nx;
        end
      arp_pkg::S_PITCH: begin
        pitch_r <= pitch_clamp;
        gprod_r <= gate_prod;
      end
      arp_pkg::S_WAIT_LEN: off_tick <= tick_r + len;
      default: ;
    endcase
  end

  // ------------------------------------------------------------ output
  always_comb begin
    m_tdata = '0;
    m_tdata[38:32] = pitch_r;
    if (state == arp_pkg::S_EMIT_OFF) begin
      m_tdata[31:0]  = off_tick;
      m_tdata[45:39] = arp_pkg::VEL_OFF;
    end else begin
      m_tdata[31:0]  = tick_r;
      m_tdata[45:39] = arp_pkg::VEL_ON;
    end
    m_tuser[0] = (state == arp_pkg::S_EMIT_ON) && (op_r == arp_pkg::OP_TICK);
    m_tlast    = (state == arp_pkg::S_EMIT_OFF);
  end

endmodule

// ----- dv/arpeggiator_engine_checker.sv -----
// ----------------------------------------------------------------------------
// arpeggiator_engine_checker
// Watches the note/tick stream, the event stream and register writes. Keeps a
// private copy of the held-note set, pattern and octave walk, predicts each
// event pair and compares every event field against the oldest prediction.
// ----------------------------------------------------------------------------
module arpeggiator_engine_checker
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // pitch_in[6:0], tick_count[38:7], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // event_tick[31:0], pitch_out[38:32], velocity[45:39]
  input  logic [0:0]  m_tuser,   // event_kind[0]
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [31:0] tick;
    logic [6:0]  pitch;
    logic [6:0]  vel;
    logic        last;
  } note_event_t;

  note_event_t event_q[$];

  logic [3:0]  cfg_mode;
  int          cfg_span;
  logic        cfg_hold;
  logic [9:0]  cfg_divisor;
  logic [6:0]  cfg_gate;

  logic [6:0]  held_pitch [MAX_NOTES];
  logic [15:0] held_age [MAX_NOTES];
  int          note_cnt, pressed_cnt, step_pos, play_idx, oct_off, oct_dir;
  logic [15:0] age_next, lfsr;

  function automatic void clear_notes();
    step_pos = -1;
    play_idx = 0;
    age_next = 0;
    oct_off = 0;
    oct_dir = 0;
    note_cnt = 0;
    pressed_cnt = 0;
  endfunction

  function automatic void add_note(logic [6:0] p);
    int pos;
    pos = 0;
    if (note_cnt >= MAX_NOTES) return;
    while (pos < note_cnt && p > held_pitch[pos]) pos++;
    if (pos < note_cnt && p == held_pitch[pos]) return;
    note_cnt++;
    pressed_cnt++;
    for (int i = note_cnt - 1; i > pos; i--) begin
      held_pitch[i] = held_pitch[i-1];
      held_age[i] = held_age[i-1];
    end
    held_pitch[pos] = p;
    held_age[pos] = age_next;
    age_next = age_next + 16'd1;
  endfunction

  function automatic void drop_note(logic [6:0] p);
    for (int i = 0; i < note_cnt; i++) begin
      if (held_pitch[i] == p) begin
        if (pressed_cnt > 0) pressed_cnt--;
        if (cfg_hold) return;
        note_cnt--;
        for (int j = i; j < note_cnt; j++) begin
          held_pitch[j] = held_pitch[j+1];
          held_age[j] = held_age[j+1];
        end
        return;
      end
    end
  endfunction

  function automatic int oldest_index(int rank);
    int r;
    for (int k = 0; k < note_cnt; k++) begin
      r = 0;
      for (int i = 0; i < note_cnt; i++)
        if (held_age[i] < held_age[k]) r++;
      if (r == rank) return k;
    end
    return 0;
  endfunction

  function automatic void advance_pattern();
    int n, s, idx;
    n = note_cnt;
    s = step_pos;
    idx = 0;
    case (cfg_mode)
      MODE_ORDER: begin
        s = (s + 1) % n;
        idx = oldest_index(s);
      end
      MODE_UP, MODE_DOWN: begin
        s = (s + 1) % n;
        idx = s;
      end
      MODE_UPDOWN, MODE_DOWNUP: begin
        if (n >= 2) begin
          s = (s + 1) % ((n - 1) * 2);
          idx = s % (n - 1);
          if (s >= n - 1) idx = n - idx - 1;
        end else begin
          s = 0;
        end
      end
      MODE_UPANDDOWN, MODE_DOWNANDUP: begin
        s = (s + 1) % (n * 2);
        idx = s % n;
        if (s >= n) idx = n - idx - 1;
      end
      MODE_CONVERGE: begin
        s = (s + 1) % n;
        idx = s / 2;
        if (s % 2 == 1) idx = n - idx - 1;
      end
      MODE_DIVERGE: begin
        s = (s + 1) % n;
        idx = s / 2;
        idx = n / 2 + ((s % 2 == 0) ? idx : -idx - 1);
      end
      MODE_RANDOM: begin
        s = (s + 1) % n;
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
        idx = int'(lfsr) % n;
      end
      default: ;
    endcase
    if (cfg_mode == MODE_DOWN || cfg_mode == MODE_DOWNUP || cfg_mode == MODE_DOWNANDUP)
      idx = n - idx - 1;
    step_pos = s;
    play_idx = idx;
  endfunction

  function automatic void advance_octave();
    int oct;
    bit both;
    oct = cfg_span;
    both = 0;
    if (oct > 5) begin
      oct -= 5;
      both = 1;
    end
    if (oct < -5) begin
      oct += 5;
      both = 1;
    end
    if (oct == 0) begin
      oct_off = 0;
      oct_dir = 0;
    end else if (oct > 0) begin
      if (oct_dir == 0) begin
        oct_dir = 1;
      end else begin
        oct_off += oct_dir;
        if (oct_off > oct) begin
          oct_off = both ? oct : 0;
          oct_dir = both ? -1 : 1;
        end else if (oct_off < 0) begin
          oct_off = 0;
          oct_dir = 1;
        end
      end
    end else begin
      if (oct_dir == 0) begin
        oct_dir = -1;
      end else begin
        oct_off += oct_dir;
        if (oct_off < oct) begin
          oct_off = both ? oct : 0;
          oct_dir = both ? 1 : -1;
        end else if (oct_off > 0) begin
          oct_off = 0;
          oct_dir = -1;
        end
      end
    end
  endfunction

  function automatic void play_item(logic [1:0] op, logic [6:0] p, logic [31:0] t);
    logic [31:0] div, len;
    int idx, pitch;
    note_event_t ev;
    if (op == OP_NOTE_ON) begin
      if (cfg_hold && pressed_cnt == 0) clear_notes();
      add_note(p);
      return;
    end
    if (op == OP_NOTE_OFF) begin
      drop_note(p);
      return;
    end
    if (op != OP_TICK) return;
    if (!cfg_hold && pressed_cnt == 0) clear_notes();
    div = ((cfg_divisor == 0) ? 32'd1 : 32'(cfg_divisor)) << TICK_SHIFT;
    if (t % div != 0 || note_cnt == 0) return;
    advance_pattern();
    if (step_pos == 0) advance_octave();
    idx = (oct_dir == -1) ? note_cnt - play_idx - 1 : play_idx;
    if (idx >= note_cnt || idx < 0) idx = 0;
    pitch = int'(held_pitch[idx]) + oct_off * 12;
    if (pitch < 0) pitch = 0;
    if (pitch > 127) pitch = 127;
    len = (div * 32'(cfg_gate)) / 32'd100;
    if (len < 1) len = 1;
    if (cfg_gate == GATE_LEGATO) len = len + 1;
    ev = '{kind: 1'b1, tick: t, pitch: 7'(pitch), vel: VEL_ON, last: 1'b0};
    event_q.push_back(ev);
    ev = '{kind: 1'b0, tick: t + len, pitch: 7'(pitch), vel: VEL_OFF, last: 1'b1};
    event_q.push_back(ev);
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    note_event_t want;
    if (rst) begin
      cfg_mode = MODE_UP;
      cfg_span = 0;
      cfg_hold = 0;
      cfg_divisor = 10'd12;
      cfg_gate = 7'd50;
      clear_notes();
      lfsr = LFSR_SEED;
      event_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MODE:   cfg_mode = pwdata[3:0];
          REG_SPAN:   cfg_span = int'($signed(pwdata[4:0]));
          REG_HOLD:   cfg_hold = pwdata[0];
          REG_DIVSOR: cfg_divisor = pwdata[9:0];
          REG_GATE:   cfg_gate = pwdata[6:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        play_item(s_tuser, s_tdata[6:0], s_tdata[38:7]);
      if (m_tvalid && m_tready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event: tick %0d pitch %0d", m_tdata[31:0], m_tdata[38:32]);
          fails++;
        end else begin
          want = event_q.pop_front();
          if (m_tuser[0] !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, m_tuser[0]);
            fails++;
          end
          if (m_tdata[31:0] !== want.tick) begin
            $error("event_tick: expected %0d, got %0d", want.tick, m_tdata[31:0]);
            fails++;
          end
          if (m_tdata[38:32] !== want.pitch) begin
            $error("pitch_out: expected %0d, got %0d", want.pitch, m_tdata[38:32]);
            fails++;
          end
          if (m_tdata[45:39] !== want.vel) begin
            $error("velocity: expected %0d, got %0d", want.vel, m_tdata[45:39]);
            fails++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            fails++;
          end
        end
      end
    end
    pending = event_q.size();
  end

endmodule

// ----- dv/arpeggiator_engine_tb.sv -----
// ----------------------------------------------------------------------------
// arpeggiator_engine_tb
// Drives note-on, note-off, clock-tick and spare-op items into the arpeggiator
// over a run of register settings and idling patterns; the checker predicts and
// compares the event pairs, and this module gives the verdict.
// ----------------------------------------------------------------------------
module arpeggiator_engine_tb;
  import arp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 3_000_000;
  localparam int SETTLE    = 500;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // pitch_in[6:0], tick_count[38:7], zero pad
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;        // event_tick[31:0], pitch_out[38:32], velocity[45:39]
  logic [0:0]  m_tuser;        // event_kind[0]
  logic        m_tlast;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails, pending;
  int cycles = 0;
  int tx_pct = 0, rx_pct = 0, rx_hold = 0;
  logic [31:0] step_len = 48;
  logic [31:0] tick_now = 0;
  logic [6:0]  recent [$];

  arpeggiator_engine dut (.*);

  arpeggiator_engine_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .fails, .pending
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic pause_input(int n);
    s_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause_input(1);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, logic [6:0] p, logic [31:0] t);
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {1'b0, t, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ($urandom_range(0, 99) < tx_pct) pause_input($urandom_range(1, 4));
  endtask

  task automatic set_regs(logic [3:0] md, logic [4:0] span, logic hold,
                          logic [9:0] dv, logic [6:0] gate);
    drain();
    reg_write(REG_MODE, 32'(md));
    reg_write(REG_SPAN, 32'(span));
    reg_write(REG_HOLD, 32'(hold));
    reg_write(REG_DIVSOR, 32'(dv));
    reg_write(REG_GATE, 32'(gate));
    step_len = ((dv == 0) ? 32'd1 : 32'(dv)) << TICK_SHIFT;
    tick_now = tick_now - tick_now % step_len;
  endtask

  task automatic random_item();
    int r;
    logic [6:0] p;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      p = 7'($urandom_range(0, 127));
      recent.push_back(p);
      if (recent.size() > 24) void'(recent.pop_front());
      send_item(OP_NOTE_ON, p, $urandom);
    end else if (r < 48) begin
      if (recent.size() > 0 && $urandom_range(0, 9) < 8)
        p = recent[$urandom_range(0, recent.size() - 1)];
      else
        p = 7'($urandom_range(0, 127));
      send_item(OP_NOTE_OFF, p, $urandom);
    end else if (r < 97) begin
      if ($urandom_range(0, 9) < 8) begin
        tick_now = tick_now + step_len;
        send_item(OP_TICK, 7'($urandom), tick_now);
      end else begin
        send_item(OP_TICK, 7'($urandom), $urandom);
      end
    end else begin
      send_item(OP_SPARE, 7'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [31:0] top_tick;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_regs(MODE_UP, 5'd0, 1'b0, 10'd12, 7'd50);
    send_item(OP_NOTE_ON, 7'd0, 32'd0);
    send_item(OP_NOTE_ON, 7'd127, 32'hFFFF_FFFF);
    send_item(OP_NOTE_ON, 7'd60, 32'd0);
    send_item(OP_NOTE_ON, 7'd60, 32'd0);
    send_item(OP_NOTE_OFF, 7'd61, 32'd0);
    send_item(OP_TICK, 7'd0, 32'd0);
    send_item(OP_TICK, 7'd0, 32'd48);
    send_item(OP_TICK, 7'd0, 32'd49);
    send_item(OP_SPARE, 7'h7F, 32'hFFFF_FFFF);
    top_tick = 32'hFFFF_FFFF - 32'hFFFF_FFFF % 48;
    send_item(OP_TICK, 7'd0, top_tick);
    send_item(OP_TICK, 7'd0, 32'hFFFF_FFFF);
    send_item(OP_NOTE_OFF, 7'd0, 32'd0);
    send_item(OP_NOTE_OFF, 7'd127, 32'd0);
    send_item(OP_NOTE_OFF, 7'd60, 32'd0);
    send_item(OP_TICK, 7'd0, 32'd96);
    for (int i = 0; i < 17; i++) send_item(OP_NOTE_ON, 7'(i * 7), 32'd0);
    send_item(OP_TICK, 7'd0, 32'd144);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_regs(MODE_ORDER, 5'd10, 1'b0, 10'd1, 7'd0);
        1: set_regs(MODE_DOWN, 5'h16, 1'b1, 10'd768, 7'd100);
        2: set_regs(MODE_RANDOM, 5'd15, 1'b0, 10'd0, 7'd127);
        3: set_regs(MODE_DIVERGE, 5'h10, 1'b1, 10'd1023, 7'd1);
        default: begin
          pick = $urandom_range(0, 9);
          set_regs(4'((pick < 8) ? ph % 10 : $urandom_range(10, 15)),
                   5'($urandom), 1'($urandom_range(0, 3) == 0),
                   10'($urandom_range(1, 40)), 7'($urandom_range(0, 127)));
        end
      endcase
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 59; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 59; end
        default: begin tx_pct = 16; rx_pct = 16; end
      endcase
      for (int i = 0; i < 102; i++) begin
        if (ph == 1 && i == 40) rx_hold = 800;
        if (ph == 2 && i == 50) begin
          pause_input(1);
          wait (pending == 0);
        end
        random_item();
      end
    end

    pause_input(1);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
